// ===== rtl/rcfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the remote control frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // Byte counter saturates here
    localparam logic [4:0] COUNT_MAX = 5'd31;

    // Stick channels
    localparam int CHAN_W = 11;
    localparam int MAG_W = 11;          // |raw - center|, up to 1024
    localparam int SCALED_W = 23;       // |raw - center| * 4096 + bias
    localparam int RECIP_W = 24;
    localparam int PROD_W = SCALED_W + RECIP_W;
    localparam int RECIP_SHIFT = 31;
    localparam int NORM_W = 16;

    localparam logic [SCALED_W-1:0] ROUND_BIAS = 23'd82;          // half of 165
    localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd13015053;      // ceil(2^31 / 165)

    // Raw switch codes as sent on the line
    localparam logic [1:0] RAW_SW_KEEP = 2'd0;
    localparam logic [1:0] RAW_SW_UP = 2'd1;
    localparam logic [1:0] RAW_SW_DOWN = 2'd2;
    localparam logic [1:0] RAW_SW_MID = 2'd3;

    typedef enum logic [1:0] {
        SW_UP   = 2'd0,
        SW_MID  = 2'd1,
        SW_DOWN = 2'd2
    } t_switch;

    function automatic t_switch next_switch(input logic [1:0] raw, input t_switch prev);
        t_switch res;
        case (raw)
            RAW_SW_UP:   res = SW_UP;
            RAW_SW_MID:  res = SW_MID;
            RAW_SW_DOWN: res = SW_DOWN;
            default:     res = prev;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/rcfd_byte_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_byte_cell
// One byte of the receive shift chain; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module rcfd_byte_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== rtl/rcfd_chan_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_chan_norm
// Stick channel scaling: round((raw - 1024) * 4096 / 165) in two stages.
// ----------------------------------------------------------------------------
module rcfd_chan_norm
    import rcfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_load_prod,
    input  logic                     i_load_out,
    input  logic [CHAN_W-1:0]        i_raw,
    output logic signed [NORM_W-1:0] o_norm
);

    logic                     w_neg;
    logic [MAG_W-1:0]         w_mag;
    logic [SCALED_W-1:0]      w_scaled;
    logic [NORM_W-1:0]        w_quot;

    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic signed [NORM_W-1:0] r_norm;
    logic signed [NORM_W-1:0] n_norm;

    // raw[10] set means raw >= 1024
    always_comb begin
        w_neg = ~i_raw[CHAN_W-1];
        if (w_neg) begin
            w_mag = MAG_W'(12'd1024 - {2'b00, i_raw[CHAN_W-2:0]});
        end else begin
            w_mag = {1'b0, i_raw[CHAN_W-2:0]};
        end
        w_scaled = {w_mag, 12'd0} + ROUND_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_neg  <= w_neg;
            r_prod <= PROD_W'(w_scaled) * PROD_W'(RECIP_MUL);
        end
    end

    // reciprocal is exact for every scaled value below 2^23
    assign w_quot = r_prod[RECIP_SHIFT +: NORM_W];

    always_comb begin
        if (r_neg) begin
            n_norm = -$signed(w_quot);
        end else begin
            n_norm = $signed(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_norm <= n_norm;
        end
    end

    assign o_norm = r_norm;

endmodule

// ===== rtl/rc_frame_receiver_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_frame_receiver_decoder
// Remote control receiver: collects UART bytes and decodes a frame on idle.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: i_cmd = 0 carries a received byte in i_byte_value, i_cmd = 1
//   marks the receive line going idle. The last FRAME_BYTES bytes sit in a
//   chain of byte cells; a saturating counter tracks bytes since last idle.
//   An idle beat with at least FRAME_BYTES bytes counted yields one result
//   beat with four scaled sticks, two switches, mouse and key fields; any
//   idle beat clears the count. Short frames give no result.
//   Throughput: one input beat per cycle while o_stall is low. A result is
//   registered first in the channel multiplier stage, then in the output
//   register.
//   While the receiver stalls, the output holds; one more result may wait in
//   the multiplier stage, after that o_stall rises until the output moves.
//   Reset clears the count, the pipeline valids and sets both switches down;
//   the byte chain is not cleared.
// ----------------------------------------------------------------------------
module rc_frame_receiver_decoder
    import rcfd_pkg::*;
#(
    parameter int FRAME_BYTES = 18
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic [7:0]               i_byte_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [NORM_W-1:0] o_right_row,
    output logic signed [NORM_W-1:0] o_right_col,
    output logic signed [NORM_W-1:0] o_left_row,
    output logic signed [NORM_W-1:0] o_left_col,
    output logic [1:0]               o_switch_left,
    output logic [1:0]               o_switch_right,
    output logic signed [15:0]       o_mouse_x,
    output logic signed [15:0]       o_mouse_y,
    output logic signed [15:0]       o_mouse_z,
    output logic                     o_mouse_left,
    output logic                     o_mouse_right,
    output logic [15:0]              o_key_bits
);

    localparam logic [4:0] FRAME_COUNT = 5'(FRAME_BYTES);

    logic [7:0] w_cell [FRAME_BYTES];
    logic [7:0] w_next [FRAME_BYTES];

    logic w_accept;
    logic w_shift;
    logic w_fire;
    logic w_out_load;
    logic w_s1_move;

    logic [CHAN_W-1:0] w_chan [4];
    t_switch w_sw_left;
    t_switch w_sw_right;

    logic [4:0] r_count;
    logic [4:0] n_count;
    t_switch    r_sw_left;
    t_switch    r_sw_right;
    logic       r_s1_valid;
    logic       r_out_valid;

    // stage 1 payload (non-channel fields)
    t_switch     r_s1_sw_left;
    t_switch     r_s1_sw_right;
    logic [15:0] r_s1_mouse_x;
    logic [15:0] r_s1_mouse_y;
    logic [15:0] r_s1_mouse_z;
    logic        r_s1_mouse_left;
    logic        r_s1_mouse_right;
    logic [15:0] r_s1_key_bits;

    // output payload
    t_switch     r_sw_left_out;
    t_switch     r_sw_right_out;
    logic [15:0] r_mouse_x;
    logic [15:0] r_mouse_y;
    logic [15:0] r_mouse_z;
    logic        r_mouse_left;
    logic        r_mouse_right;
    logic [15:0] r_key_bits;

    // ---------------- handshake ----------------
    assign w_out_load = ~r_out_valid | ~i_stall;
    assign w_s1_move  = w_out_load & r_s1_valid;
    assign o_stall    = r_s1_valid & ~w_out_load;
    assign w_accept   = i_valid & ~o_stall;
    assign w_shift    = w_accept & ~i_cmd;
    assign w_fire     = w_accept & i_cmd & (r_count >= FRAME_COUNT);

    // ---------------- byte chain, oldest in cell 0 ----------------
    genvar g;
    generate
        for (g = 0; g < FRAME_BYTES; g++) begin : g_cell
            if (g == FRAME_BYTES - 1) begin : g_tail
                assign w_next[g] = i_byte_value;
            end else begin : g_body
                assign w_next[g] = w_cell[g+1];
            end
            rcfd_byte_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_byte (w_next[g]),
                .o_byte (w_cell[g])
            );
        end
    endgenerate

    // ---------------- byte counter ----------------
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (i_cmd) begin
                n_count = '0;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 5'd1;
            end
        end
    end

    // ---------------- field unpack ----------------
    assign w_chan[0] = {w_cell[1][2:0], w_cell[0]};
    assign w_chan[1] = {w_cell[2][5:0], w_cell[1][7:3]};
    assign w_chan[2] = {w_cell[4][0], w_cell[3], w_cell[2][7:6]};
    assign w_chan[3] = {w_cell[5][3:0], w_cell[4][7:1]};

    assign w_sw_right = next_switch(w_cell[5][5:4], r_sw_right);
    assign w_sw_left  = next_switch(w_cell[5][7:6], r_sw_left);

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sw_left   <= SW_DOWN;
            r_sw_right  <= SW_DOWN;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_sw_left  <= w_sw_left;
                r_sw_right <= w_sw_right;
            end
            if (w_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1_sw_left     <= w_sw_left;
            r_s1_sw_right    <= w_sw_right;
            r_s1_mouse_x     <= {w_cell[7], w_cell[6]};
            r_s1_mouse_y     <= {w_cell[9], w_cell[8]};
            r_s1_mouse_z     <= {w_cell[11], w_cell[10]};
            r_s1_mouse_left  <= |w_cell[12];
            r_s1_mouse_right <= |w_cell[13];
            r_s1_key_bits    <= {w_cell[15], w_cell[14]};
        end
        if (w_s1_move) begin
            r_sw_left_out  <= r_s1_sw_left;
            r_sw_right_out <= r_s1_sw_right;
            r_mouse_x      <= r_s1_mouse_x;
            r_mouse_y      <= r_s1_mouse_y;
            r_mouse_z      <= r_s1_mouse_z;
            r_mouse_left   <= r_s1_mouse_left;
            r_mouse_right  <= r_s1_mouse_right;
            r_key_bits     <= r_s1_key_bits;
        end
    end

    // ---------------- stick channels ----------------
    rcfd_chan_norm u_norm_right_row (
        .i_clk      (i_clk),
        .i_load_prod(w_fire),
        .i_load_out (w_s1_move),
        .i_raw      (w_chan[0]),
        .o_norm     (o_right_row)
    );

    rcfd_chan_norm u_norm_right_col (
        .i_clk      (i_clk),
        .i_load_prod(w_fire),
        .i_load_out (w_s1_move),
        .i_raw      (w_chan[1]),
        .o_norm     (o_right_col)
    );

    rcfd_chan_norm u_norm_left_row (
        .i_clk      (i_clk),
        .i_load_prod(w_fire),
        .i_load_out (w_s1_move),
        .i_raw      (w_chan[2]),
        .o_norm     (o_left_row)
    );

    rcfd_chan_norm u_norm_left_col (
        .i_clk      (i_clk),
        .i_load_prod(w_fire),
        .i_load_out (w_s1_move),
        .i_raw      (w_chan[3]),
        .o_norm     (o_left_col)
    );

    // ---------------- outputs ----------------
    assign o_valid        = r_out_valid;
    assign o_switch_left  = r_sw_left_out;
    assign o_switch_right = r_sw_right_out;
    assign o_mouse_x      = $signed(r_mouse_x);
    assign o_mouse_y      = $signed(r_mouse_y);
    assign o_mouse_z      = $signed(r_mouse_z);
    assign o_mouse_left   = r_mouse_left;
    assign o_mouse_right  = r_mouse_right;
    assign o_key_bits     = r_key_bits;

endmodule
